### rtl/rc4_pkg.sv
// Shared constants and types for the RC4 stream cipher block.
`timescale 1ns / 1ps
package rc4_pkg;

   // Permutation geometry.
   localparam int IDX_W      = 8;
   localparam int BYTE_W     = 8;
   localparam int PERM_DEPTH = 1 << IDX_W;

   // Key storage geometry.
   localparam int MAX_KEY_BYTES  = 32;
   localparam int KEY_IDX_W      = $clog2(MAX_KEY_BYTES);
   localparam int KEY_LEN_W      = 6;
   localparam int KEY_WORD_W     = 64;
   localparam int BYTES_PER_WORD = KEY_WORD_W / BYTE_W;
   localparam int BYTE_SEL_W     = $clog2(BYTES_PER_WORD);
   localparam int KEY_WORDS      = MAX_KEY_BYTES / BYTES_PER_WORD;
   localparam int WORD_SEL_W     = $clog2(KEY_WORDS);

   // Control/status port geometry and register map.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = KEY_WORD_W;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_3 = 3'd4;

   // Command codes carried on the request tuser.
   localparam logic CMD_CRYPT = 1'b0;
   localparam logic CMD_REKEY = 1'b1;

   // Key information handed from the register file to the sequencer.
   typedef struct packed {
      logic [KEY_LEN_W-1:0] len_sat;
      logic [BYTE_W-1:0]    key_byte;
   } key_info_type;

endpackage

### rtl/rc4_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port; a same-address read returns old data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/rc4_key_regs.sv
// Key length and key byte registers with key byte selection.
`timescale 1ns / 1ps
module rc4_key_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rc4_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [rc4_pkg::KEY_IDX_W-1:0]    key_idx,
   output rc4_pkg::key_info_type            key_info
);
   import rc4_pkg::*;

   logic [KEY_LEN_W-1:0]  key_len_ff;
   logic [KEY_WORD_W-1:0] key_word_ff [KEY_WORDS];
   logic [KEY_WORD_W-1:0] sel_word;
   logic [WORD_SEL_W-1:0] word_sel;
   logic [BYTE_SEL_W-1:0] byte_sel;

   // Register writes; indexes beyond the map are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= KEY_LEN_W'(1);
         for (int w = 0; w < KEY_WORDS; w++) begin
            key_word_ff[w] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            REG_KEY_LENGTH: key_len_ff     <= csr_wdata[KEY_LEN_W-1:0];
            REG_KEY_WORD_0: key_word_ff[0] <= csr_wdata;
            REG_KEY_WORD_1: key_word_ff[1] <= csr_wdata;
            REG_KEY_WORD_2: key_word_ff[2] <= csr_wdata;
            REG_KEY_WORD_3: key_word_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Byte k lives in word k/8 at byte lane k%8.
   assign word_sel = key_idx[KEY_IDX_W-1 -: WORD_SEL_W];
   assign byte_sel = key_idx[BYTE_SEL_W-1:0];
   assign sel_word = key_word_ff[word_sel];

   always_comb begin
      key_info.key_byte = sel_word[byte_sel*BYTE_W +: BYTE_W];
      // Lengths above the key store saturate to its size.
      if (key_len_ff > KEY_LEN_W'(MAX_KEY_BYTES)) begin
         key_info.len_sat = KEY_LEN_W'(MAX_KEY_BYTES);
      end else begin
         key_info.len_sat = key_len_ff;
      end
   end

endmodule

### rtl/rc4_core.sv
// Sequencer for the key schedule and the crypt step around the permutation RAM.
`timescale 1ns / 1ps
module rc4_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_tuser,
   input  logic [rc4_pkg::BYTE_W-1:0]     req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rc4_pkg::BYTE_W-1:0]     rsp_tdata,
   output logic [rc4_pkg::KEY_IDX_W-1:0]  key_idx,
   input  rc4_pkg::key_info_type          key_info,
   output logic                           ram_we,
   output logic [rc4_pkg::IDX_W-1:0]      ram_waddr,
   output logic [rc4_pkg::BYTE_W-1:0]     ram_wdata,
   output logic [rc4_pkg::IDX_W-1:0]      ram_raddr,
   input  logic [rc4_pkg::BYTE_W-1:0]     ram_rdata
);
   import rc4_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] ST_C_J   = 4'd1;
   localparam logic [ST_W-1:0] ST_C_SEL = 4'd2;
   localparam logic [ST_W-1:0] ST_C_OUT = 4'd3;
   localparam logic [ST_W-1:0] ST_K_RDI = 4'd4;
   localparam logic [ST_W-1:0] ST_K_RDJ = 4'd5;
   localparam logic [ST_W-1:0] ST_K_WRI = 4'd6;
   localparam logic [ST_W-1:0] ST_K_WRJ = 4'd7;

   logic [ST_W-1:0]      state_ff, state_in;
   logic [IDX_W-1:0]     fi_ff, fi_in, fj_ff, fj_in;
   logic [IDX_W-1:0]     ki_ff, ki_in, kj_ff, kj_in;
   logic [KEY_IDX_W-1:0] kk_ff, kk_in;
   logic [BYTE_W-1:0]    si_ff, si_in, sj_ff, sj_in;
   logic [IDX_W-1:0]     sel_ff, sel_in;
   logic [BYTE_W-1:0]    data_ff, data_in;
   logic                 ident_ff, ident_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [PERM_DEPTH-1:0] valid_ff;
   logic                 vld_q_ff;
   logic [IDX_W-1:0]     raddr_q_ff;
   logic                 clear_valid;
   logic [BYTE_W-1:0]    rd_val;
   logic [BYTE_W-1:0]    ks;
   logic [KEY_LEN_W-1:0] kk_next;

   // Entries never written since the last rekey read as identity, or as zero after reset.
   always_comb begin
      if (vld_q_ff) begin
         rd_val = ram_rdata;
      end else if (ident_ff) begin
         rd_val = raddr_q_ff;
      end else begin
         rd_val = '0;
      end
   end

   // Keystream byte: the swap writes of this step are forwarded over the RAM read.
   always_comb begin
      if (sel_ff == fj_ff) begin
         ks = si_ff;
      end else if (sel_ff == fi_ff) begin
         ks = sj_ff;
      end else begin
         ks = rd_val;
      end
   end

   assign kk_next = KEY_LEN_W'(kk_ff) + KEY_LEN_W'(1);
   assign key_idx = kk_ff;

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      fi_in        = fi_ff;
      fj_in        = fj_ff;
      ki_in        = ki_ff;
      kj_in        = kj_ff;
      kk_in        = kk_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      sel_in       = sel_ff;
      data_in      = data_ff;
      ident_in     = ident_ff;
      clear_valid  = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = (state_ff == ST_IDLE);
      ram_raddr    = fi_ff + IDX_W'(1);
      ram_we       = 1'b0;
      ram_waddr    = fi_ff;
      ram_wdata    = sj_ff;
      case (state_ff)
         ST_IDLE: begin
            // The read of the next first-index entry is issued while waiting.
            if (req_tvalid) begin
               if (req_tuser == CMD_REKEY) begin
                  if (key_info.len_sat != '0) begin
                     clear_valid = 1'b1;
                     ident_in    = 1'b1;
                     fi_in       = '0;
                     fj_in       = '0;
                     ki_in       = '0;
                     kj_in       = '0;
                     kk_in       = '0;
                     state_in    = ST_K_RDI;
                  end
               end else begin
                  fi_in    = fi_ff + IDX_W'(1);
                  data_in  = req_tdata;
                  state_in = ST_C_J;
               end
            end
         end
         ST_C_J: begin
            si_in     = rd_val;
            fj_in     = fj_ff + rd_val;
            ram_raddr = fj_ff + rd_val;
            state_in  = ST_C_SEL;
         end
         ST_C_SEL: begin
            sj_in     = rd_val;
            ram_we    = 1'b1;
            ram_waddr = fi_ff;
            ram_wdata = rd_val;
            sel_in    = si_ff + rd_val;
            ram_raddr = si_ff + rd_val;
            state_in  = ST_C_OUT;
         end
         ST_C_OUT: begin
            // Finish the swap and load the output word once the slot is free.
            ram_raddr = sel_ff;
            if (!rsp_valid_ff || rsp_tready) begin
               ram_we       = 1'b1;
               ram_waddr    = fj_ff;
               ram_wdata    = si_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff ^ ks;
               state_in     = ST_IDLE;
            end
         end
         ST_K_RDI: begin
            ram_raddr = ki_ff;
            state_in  = ST_K_RDJ;
         end
         ST_K_RDJ: begin
            si_in     = rd_val;
            kj_in     = kj_ff + rd_val + key_info.key_byte;
            ram_raddr = kj_ff + rd_val + key_info.key_byte;
            state_in  = ST_K_WRI;
         end
         ST_K_WRI: begin
            ram_we    = 1'b1;
            ram_waddr = ki_ff;
            ram_wdata = rd_val;
            state_in  = ST_K_WRJ;
         end
         ST_K_WRJ: begin
            ram_we    = 1'b1;
            ram_waddr = kj_ff;
            ram_wdata = si_ff;
            ki_in     = ki_ff + IDX_W'(1);
            if (kk_next >= key_info.len_sat) begin
               kk_in = '0;
            end else begin
               kk_in = kk_next[KEY_IDX_W-1:0];
            end
            if (ki_ff == IDX_W'(PERM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_K_RDI;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fi_ff        <= '0;
         fj_ff        <= '0;
         ki_ff        <= '0;
         kj_ff        <= '0;
         kk_ff        <= '0;
         ident_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fi_ff        <= fi_in;
         fj_ff        <= fj_in;
         ki_ff        <= ki_in;
         kj_ff        <= kj_in;
         kk_ff        <= kk_in;
         ident_ff     <= ident_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Per-entry written flags for the permutation RAM.
   always_ff @(posedge clock) begin
      if (reset || clear_valid) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[ram_waddr] <= 1'b1;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      sel_ff      <= sel_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
      vld_q_ff    <= valid_ff[ram_raddr];
      raddr_q_ff  <= ram_raddr;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher block.
`timescale 1ns / 1ps
//
//   Channel   Direction   Ports        Contents
//   req       in          req_t*       tuser: cmd; tdata: data_byte
//   rsp       out         rsp_t*       tdata: out_byte
//   csr       in          csr_*        write-only key length and key words
//
// A crypt word steps through ST_C_J, ST_C_SEL and ST_C_OUT; rsp_tvalid rises as it
// leaves ST_C_OUT for ST_IDLE: three dependent reads of the single-read-port permutation
// RAM and two swap writes. The next word is accepted only once the sequencer is in ST_IDLE.
// A rekey word holds req_tready low for 256 swaps through ST_K_RDI, ST_K_RDJ, ST_K_WRI
// and ST_K_WRJ. A rekey with a zero key length is dropped at once and gives no word.
// Reset is synchronous; after reset the permutation reads as all zeros.
// A stalled output word holds the sequencer in its last crypt cycle.
module rc4_stream_cipher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_tuser,   // [0] cmd
   input  logic [rc4_pkg::BYTE_W-1:0]     req_tdata,   // [7:0] data_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rc4_pkg::BYTE_W-1:0]     rsp_tdata,   // [7:0] out_byte
   input  logic                           csr_we,
   input  logic [rc4_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rc4_pkg::*;

   key_info_type         key_info;
   logic [KEY_IDX_W-1:0] key_idx;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [BYTE_W-1:0]    ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [BYTE_W-1:0]    ram_rdata;

   // Key registers.
   rc4_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key_idx   (key_idx),
      .key_info  (key_info)
   );

   // Permutation store.
   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PERM_DEPTH)
   ) u_perm_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Sequencer.
   rc4_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .key_idx    (key_idx),
      .key_info   (key_info),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

endmodule

### rtl/rc4_chk.sv
// Port-level assertions for the RC4 stream cipher block, bound to the top level.
`timescale 1ns / 1ps
module rc4_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rc4_pkg::BYTE_W-1:0]     rsp_tdata
);
   import rc4_pkg::*;

   logic crypt_acc;

   assign crypt_acc = req_tvalid && req_tready && (req_tuser == CMD_CRYPT);

   // A stalled output word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output word changed while stalled");

   // A crypt word occupies the sequencer, so the next cycle cannot accept.
   a_busy_after_crypt: assert property (@(posedge clock) disable iff (reset)
      crypt_acc |=> !req_tready)
      else $error("request accepted while a crypt word is in progress");

   // Every crypt word must be followed by a pending output word.
   a_crypt_latency: assert property (@(posedge clock) disable iff (reset)
      crypt_acc |-> ##4 rsp_tvalid)
      else $error("crypt word produced no output word");

   // An output word only appears after a crypt word.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(crypt_acc, 4))
      else $error("output word without a matching crypt word");

endmodule

bind rc4_stream_cipher rc4_chk u_chk (.*);
